FILE: rtl/pidpd_pkg.sv
`default_nettype none

package pidpd_pkg;

  // Stream payload
  localparam int DATA_W     = 16;  // setpoint, feedback, drive
  localparam int IN_TDATA_W = 2 * DATA_W;

  // Stored state widths (fixed by the number format, independent of FRAC_BITS)
  localparam int ERR_W  = 26;      // filtered error history
  localparam int INT_W  = 24;      // integral accumulator and held output

  // Fixed point
  localparam int FRAC_BITS_DEF  = 8;   // Q16.8 by default
  localparam int GAIN_W         = 16;  // unsigned Q8.8
  localparam int GAIN_FRAC      = 8;
  localparam int ALPHA_NUM      = 179; // 0.7 ~ 179/256
  localparam int ALPHA_DEN_BITS = 8;
  localparam int ALPHA_RAW      = (1 << ALPHA_DEN_BITS) - ALPHA_NUM;

  // Configuration registers
  localparam int LIM_W      = 15;
  localparam int WIN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDUP_WINDOW  = 3'd6;

  localparam logic [LIM_W-1:0] LIM_RST = '1;
  localparam logic [WIN_W-1:0] WIN_RST = '1;

  // Loop modes
  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  // Input action codes
  localparam logic ACT_STEP  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/pid_controller_pos_delta.sv
`default_nettype none

// Fixed-point PID controller, positional or incremental, one control tick per
// input transfer. A tick forms (setpoint - feedback) in Q.FRAC_BITS, low-pass
// filters it as floor((77*raw + 179*e_prev)/256), then runs positional PID
// (P + windowed, clamped I + first-difference D) or incremental PID (held
// output += P, I and second-difference D increments); the output is clamped
// to +-output_limit and drive is the held output floored to integer units.
// An input with tuser set (clear) zeroes all state and returns drive 0.
// Every product runs through one shift-add multiplier that consumes the gain
// one bit per cycle, LSB first, and stops once the remaining gain bits are
// zero. A tick has five products (two filter taps, P, D, I); each is a load
// step (ST_LOAD) followed by the shift-add run (ST_RUN), so a gain with fewer
// significant bits finishes sooner. After the accept in ST_IDLE and the five
// products come ST_ICLAMP (positional mode only), ST_FIN and ST_OUT, which
// waits for the output register to be free; a clear goes from ST_IDLE
// straight to ST_OUT.
// One item is in flight at a time; the output register lets the next item be
// accepted while the last result still waits on m_axis_tready.
// Configuration writes are accepted every cycle and must only be issued while
// the controller is idle.
module pid_controller_pos_delta #(
  parameter int FRAC_BITS = pidpd_pkg::FRAC_BITS_DEF  // 4 .. 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pidpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pidpd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [pidpd_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // [15:0] setpoint, [31:16] feedback
  input  wire logic                             s_axis_tuser,  // [0] action
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [pidpd_pkg::DATA_W-1:0]          m_axis_tdata   // [15:0] drive
);
  import pidpd_pkg::*;

  // Datapath widths
  localparam int RAW_W  = DATA_W + 1 + FRAC_BITS;                 // shifted raw error
  localparam int OP_W   = (ERR_W + 2 > RAW_W) ? ERR_W + 2 : RAW_W;
  localparam int ACC_W  = OP_W + GAIN_W + 1;                      // product accumulator
  localparam int FL_W   = ACC_W - GAIN_FRAC;                      // floored product
  localparam int IS_W   = FL_W + 1;                               // integral sum
  localparam int TOT_W  = FL_W + 2;                               // output sum
  localparam int LIMF_W = LIM_W + FRAC_BITS;
  localparam int WINF_W = WIN_W + FRAC_BITS;
  localparam int CMP_W  = (WINF_W > ERR_W) ? WINF_W : ERR_W;

  localparam logic signed [FL_W-1:0]  E_HI = FL_W'((2 ** (ERR_W - 1)) - 1);
  localparam logic signed [FL_W-1:0]  E_LO = ~E_HI;
  localparam logic signed [IS_W-1:0]  I_HI = IS_W'((2 ** (INT_W - 1)) - 1);
  localparam logic signed [IS_W-1:0]  I_LO = ~I_HI;
  localparam logic signed [TOT_W-1:0] H_HI = TOT_W'((2 ** (INT_W - 1)) - 1);
  localparam logic signed [TOT_W-1:0] H_LO = ~H_HI;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_ICLAMP,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_FILT_RAW,
    PH_FILT_PREV,
    PH_PROP,
    PH_DERIV,
    PH_INTEG
  } phase_e;

  // Configuration registers
  logic              mode_q;
  logic [GAIN_W-1:0] gp_q, gi_q, gd_q;
  logic [LIM_W-1:0]  olim_q, ilim_q;
  logic [WIN_W-1:0]  win_q;

  // Control and state
  state_e                    state_q;
  phase_e                    phase_q;
  logic signed [DATA_W:0]    diff_q;
  logic signed [ERR_W-1:0]   err_now_q, err_prev_q, err_prev2_q;
  logic signed [INT_W-1:0]   ia_q, held_q;
  logic [GAIN_W-1:0]         gain_q;
  logic signed [ACC_W-1:0]   op_q, acc_q;
  logic signed [TOT_W-1:0]   tot_q;
  logic                      in_win_q;
  logic                      m_valid_q;
  logic [DATA_W-1:0]         m_data_q;

  // Combinational helpers
  logic signed [FL_W-1:0]    fl_gain, fl_filt;
  logic signed [ERR_W-1:0]   err_new;
  logic signed [OP_W-1:0]    e_x, ep_x, ep2_x, raw_x, d1_x, d2_x, op_sel;
  logic [GAIN_W-1:0]         gain_sel;
  logic [ERR_W-1:0]          abs_e;
  logic [WINF_W-1:0]         win_f;
  logic                      in_win;
  logic signed [IS_W-1:0]    ia_sum;
  logic signed [INT_W-1:0]   ia_upd, ia_clamp, ilim_s;
  logic [LIMF_W-1:0]         ilim_f, olim_f;
  logic                      ilim_big;
  logic signed [TOT_W-1:0]   olim_s, tot_clamp;
  logic signed [INT_W-1:0]   held_new;
  logic                      s_xfer, m_free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_free        = !m_valid_q || m_axis_tready;

  // Configuration; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_POS;
      gp_q   <= '0;
      gi_q   <= '0;
      gd_q   <= '0;
      olim_q <= LIM_RST;
      ilim_q <= LIM_RST;
      win_q  <= WIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_LOOP_MODE:      mode_q <= cfg_data_i[0];
        REG_GAIN_P:         gp_q   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:         gi_q   <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:         gd_q   <= cfg_data_i[GAIN_W-1:0];
        REG_OUTPUT_LIMIT:   olim_q <= cfg_data_i[LIM_W-1:0];
        REG_INTEGRAL_LIMIT: ilim_q <= cfg_data_i[LIM_W-1:0];
        REG_WINDUP_WINDOW:  win_q  <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Floors of the finished product; both shifts are arithmetic (toward -inf)
  assign fl_gain = FL_W'(acc_q >>> GAIN_FRAC);
  assign fl_filt = FL_W'(acc_q >>> ALPHA_DEN_BITS);

  always_comb begin
    if (fl_filt > E_HI) begin
      err_new = ERR_W'(E_HI);
    end else if (fl_filt < E_LO) begin
      err_new = ERR_W'(E_LO);
    end else begin
      err_new = ERR_W'(fl_filt);
    end
  end

  // Multiplier operands
  assign e_x   = OP_W'(err_now_q);
  assign ep_x  = OP_W'(err_prev_q);
  assign ep2_x = OP_W'(err_prev2_q);
  assign raw_x = OP_W'(diff_q) <<< FRAC_BITS;
  assign d1_x  = e_x - ep_x;
  assign d2_x  = e_x - (ep_x <<< 1) + ep2_x;

  always_comb begin
    case (phase_q)
      PH_FILT_RAW: begin
        gain_sel = GAIN_W'(ALPHA_RAW);
        op_sel   = raw_x;
      end
      PH_FILT_PREV: begin
        gain_sel = GAIN_W'(ALPHA_NUM);
        op_sel   = e_x;
      end
      PH_PROP: begin
        gain_sel = gp_q;
        op_sel   = (mode_q == MODE_INC) ? d1_x : e_x;
      end
      PH_DERIV: begin
        gain_sel = gd_q;
        op_sel   = (mode_q == MODE_INC) ? d2_x : d1_x;
      end
      PH_INTEG: begin
        gain_sel = gi_q;
        op_sel   = e_x;
      end
      default: begin
        gain_sel = '0;
        op_sel   = '0;
      end
    endcase
  end

  // Anti-windup window: |e| < window << FRAC_BITS
  assign abs_e  = err_now_q[ERR_W-1] ? ERR_W'(-err_now_q) : ERR_W'(err_now_q);
  assign win_f  = {win_q, {FRAC_BITS{1'b0}}};
  assign in_win = CMP_W'(abs_e) < CMP_W'(win_f);

  // Integral update and clamp
  assign ia_sum = IS_W'(ia_q) + IS_W'(fl_gain);

  always_comb begin
    if (ia_sum > I_HI) begin
      ia_upd = INT_W'(I_HI);
    end else if (ia_sum < I_LO) begin
      ia_upd = INT_W'(I_LO);
    end else begin
      ia_upd = INT_W'(ia_sum);
    end
  end

  // A limit at or above the 24-bit range leaves the saturated value alone
  assign ilim_f   = {ilim_q, {FRAC_BITS{1'b0}}};
  assign ilim_big = (ilim_f >> (INT_W - 1)) != '0;
  assign ilim_s   = $signed(INT_W'(ilim_f));

  always_comb begin
    if (ilim_big) begin
      ia_clamp = ia_q;
    end else if (ia_q > ilim_s) begin
      ia_clamp = ilim_s;
    end else if (ia_q < -ilim_s) begin
      ia_clamp = -ilim_s;
    end else begin
      ia_clamp = ia_q;
    end
  end

  // Output clamp, then saturate to the held-output width
  assign olim_f = {olim_q, {FRAC_BITS{1'b0}}};
  assign olim_s = $signed(TOT_W'(olim_f));

  always_comb begin
    if (tot_q > olim_s) begin
      tot_clamp = olim_s;
    end else if (tot_q < -olim_s) begin
      tot_clamp = -olim_s;
    end else begin
      tot_clamp = tot_q;
    end
    if (tot_clamp > H_HI) begin
      held_new = INT_W'(H_HI);
    end else if (tot_clamp < H_LO) begin
      held_new = INT_W'(H_LO);
    end else begin
      held_new = INT_W'(tot_clamp);
    end
  end

  // Sequencer, shift-add multiplier and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_FILT_RAW;
      diff_q      <= '0;
      err_now_q   <= '0;
      err_prev_q  <= '0;
      err_prev2_q <= '0;
      ia_q        <= '0;
      held_q      <= '0;
      gain_q      <= '0;
      op_q        <= '0;
      acc_q       <= '0;
      tot_q       <= '0;
      in_win_q    <= 1'b0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
    end else begin
      // in ST_OUT the output register is reloaded below instead
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            if (s_axis_tuser == ACT_CLEAR) begin
              err_now_q   <= '0;
              err_prev_q  <= '0;
              err_prev2_q <= '0;
              ia_q        <= '0;
              held_q      <= '0;
              state_q     <= ST_OUT;
            end else begin
              diff_q  <= $signed({s_axis_tdata[DATA_W-1], s_axis_tdata[DATA_W-1:0]})
                       - $signed({s_axis_tdata[IN_TDATA_W-1],
                                  s_axis_tdata[IN_TDATA_W-1:DATA_W]});
              phase_q <= PH_FILT_RAW;
              state_q <= ST_LOAD;
            end
          end
        end

        ST_LOAD: begin
          gain_q <= gain_sel;
          op_q   <= ACC_W'(op_sel);
          // second filter tap sums onto the first before the floor
          if (phase_q != PH_FILT_PREV) begin
            acc_q <= '0;
          end
          if (phase_q == PH_INTEG) begin
            in_win_q <= in_win;
          end
          state_q <= ST_RUN;
        end

        ST_RUN: begin
          if (gain_q != '0) begin
            if (gain_q[0]) begin
              acc_q <= acc_q + op_q;
            end
            op_q   <= op_q <<< 1;
            gain_q <= gain_q >> 1;
          end else begin
            state_q <= ST_LOAD;
            case (phase_q)
              PH_FILT_RAW: begin
                phase_q <= PH_FILT_PREV;
              end
              PH_FILT_PREV: begin
                err_prev2_q <= err_prev_q;
                err_prev_q  <= err_now_q;
                err_now_q   <= err_new;
                tot_q       <= (mode_q == MODE_INC) ? TOT_W'(held_q) : '0;
                phase_q     <= PH_PROP;
              end
              PH_PROP: begin
                tot_q   <= tot_q + TOT_W'(fl_gain);
                phase_q <= PH_DERIV;
              end
              PH_DERIV: begin
                tot_q   <= tot_q + TOT_W'(fl_gain);
                phase_q <= PH_INTEG;
              end
              PH_INTEG: begin
                if (mode_q == MODE_POS) begin
                  if (in_win_q) begin
                    ia_q <= ia_upd;
                  end
                  state_q <= ST_ICLAMP;
                end else begin
                  tot_q   <= tot_q + TOT_W'(fl_gain);
                  state_q <= ST_FIN;
                end
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end

        ST_ICLAMP: begin
          ia_q    <= ia_clamp;
          tot_q   <= tot_q + TOT_W'(ia_clamp);
          state_q <= ST_FIN;
        end

        ST_FIN: begin
          held_q  <= held_new;
          state_q <= ST_OUT;
        end

        ST_OUT: begin
          if (m_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= DATA_W'(held_q >>> FRAC_BITS);
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
